FILE: src/sdm_pkg.sv
// Shared types and constants for the spectral derivative multiplier.
package sdm_pkg;

  // Register field widths.
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned AXIS_W  = 2;
  localparam int unsigned START_W = 16;

  // Wavenumber width; holds k and -k for every register setting.
  localparam int unsigned K_W   = 20;
  localparam int unsigned OUT_W = 42;

  // Configuration port.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_SIZE_AXIS0  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SIZE_AXIS1  = 3'd1;
  localparam logic [IDX_W-1:0] REG_SIZE_AXIS2  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DERIV_AXIS  = 3'd3;
  localparam logic [IDX_W-1:0] REG_GLOBAL_START = 3'd4;
  localparam logic [IDX_W-1:0] REG_GLOBAL_SIZE = 3'd5;
  localparam logic [IDX_W-1:0] REG_HALVED_AXIS = 3'd6;

  localparam logic [AXIS_W-1:0] AXIS_0 = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_1 = 2'd1;

  typedef struct packed {
    logic [SIZE_W-1:0]  size_axis0;
    logic [SIZE_W-1:0]  size_axis1;
    logic [SIZE_W-1:0]  size_axis2;
    logic [AXIS_W-1:0]  deriv_axis;
    logic [START_W-1:0] global_start;
    logic [SIZE_W-1:0]  global_size;
    logic               halved_axis;
  } cfg_t;

endpackage

FILE: src/sdm_cfg_regs.sv
// Configuration register file behind the APB-style port.
module sdm_cfg_regs
  import sdm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t             cfg_q;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_axis0   <= SIZE_W'(1);
      cfg_q.size_axis1   <= SIZE_W'(1);
      cfg_q.size_axis2   <= SIZE_W'(1);
      cfg_q.deriv_axis   <= '0;
      cfg_q.global_start <= '0;
      cfg_q.global_size  <= SIZE_W'(1);
      cfg_q.halved_axis  <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_SIZE_AXIS0:   cfg_q.size_axis0   <= pwdata[SIZE_W-1:0];
        REG_SIZE_AXIS1:   cfg_q.size_axis1   <= pwdata[SIZE_W-1:0];
        REG_SIZE_AXIS2:   cfg_q.size_axis2   <= pwdata[SIZE_W-1:0];
        REG_DERIV_AXIS:   cfg_q.deriv_axis   <= pwdata[AXIS_W-1:0];
        REG_GLOBAL_START: cfg_q.global_start <= pwdata[START_W-1:0];
        REG_GLOBAL_SIZE:  cfg_q.global_size  <= pwdata[SIZE_W-1:0];
        REG_HALVED_AXIS:  cfg_q.halved_axis  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SIZE_AXIS0:   prdata = DATA_W'(cfg_q.size_axis0);
      REG_SIZE_AXIS1:   prdata = DATA_W'(cfg_q.size_axis1);
      REG_SIZE_AXIS2:   prdata = DATA_W'(cfg_q.size_axis2);
      REG_DERIV_AXIS:   prdata = DATA_W'(cfg_q.deriv_axis);
      REG_GLOBAL_START: prdata = DATA_W'(cfg_q.global_start);
      REG_GLOBAL_SIZE:  prdata = DATA_W'(cfg_q.global_size);
      REG_HALVED_AXIS:  prdata = DATA_W'(cfg_q.halved_axis);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: src/sdm_wavenum.sv
// Block position counters and wavenumber for the current coefficient.
module sdm_wavenum
  import sdm_pkg::*;
#(
  parameter int unsigned MAX_LEN = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  step_i,
  output logic signed [K_W-1:0] k_o,
  output logic signed [K_W-1:0] nk_o,
  output logic                  last_o
);

  localparam int unsigned POS_W = $clog2(MAX_LEN);
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned CMP_W = POS_W + 1;

  // Clamp a length register: zero acts as one, above MAX_LEN saturates.
  function automatic logic [CMP_W-1:0] eff_len(input logic [SIZE_W-1:0] s);
    logic [LEN_W-1:0] l;
    if (s == '0) l = LEN_W'(1);
    else if (s > SIZE_W'(MAX_LEN)) l = LEN_W'(MAX_LEN);
    else l = s[LEN_W-1:0];
    return CMP_W'(l);
  endfunction

  logic [POS_W-1:0] pos0_q, pos1_q, pos2_q;
  logic [POS_W-1:0] pos0_d, pos1_d, pos2_d;
  logic [CMP_W-1:0] inc0, inc1, inc2;
  logic             wrap0, wrap1, wrap2;

  logic [POS_W-1:0]      p;
  logic signed [K_W-1:0] p_s, start_s, gsz_s, g_s, half_s, mid_s, k;

  assign inc0  = CMP_W'(pos0_q) + CMP_W'(1);
  assign inc1  = CMP_W'(pos1_q) + CMP_W'(1);
  assign inc2  = CMP_W'(pos2_q) + CMP_W'(1);
  assign wrap0 = inc0 >= eff_len(cfg_i.size_axis0);
  assign wrap1 = inc1 >= eff_len(cfg_i.size_axis1);
  assign wrap2 = inc2 >= eff_len(cfg_i.size_axis2);
  assign last_o = wrap0 && wrap1 && wrap2;

  // Axis 0 fastest; carry ripples into the slower axes.
  always_comb begin
    pos0_d = pos0_q;
    pos1_d = pos1_q;
    pos2_d = pos2_q;
    if (step_i) begin
      pos0_d = wrap0 ? '0 : inc0[POS_W-1:0];
      if (wrap0) begin
        pos1_d = wrap1 ? '0 : inc1[POS_W-1:0];
        if (wrap1) pos2_d = wrap2 ? '0 : inc2[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos0_q <= '0;
      pos1_q <= '0;
      pos2_q <= '0;
    end else begin
      pos0_q <= pos0_d;
      pos1_q <= pos1_d;
      pos2_q <= pos2_d;
    end
  end

  always_comb begin
    case (cfg_i.deriv_axis)
      AXIS_0:  p = pos0_q;
      AXIS_1:  p = pos1_q;
      default: p = pos2_q;
    endcase
  end

  // Period g, g/2 and the Nyquist index in signed arithmetic.
  assign p_s     = signed'(K_W'(p));
  assign start_s = signed'(K_W'(cfg_i.global_start));
  assign gsz_s   = signed'(K_W'(cfg_i.global_size));
  assign half_s  = cfg_i.halved_axis ? (gsz_s - K_W'(1)) : (gsz_s >>> 1);
  assign g_s     = cfg_i.halved_axis ? (half_s <<< 1) : gsz_s;
  assign mid_s   = half_s - start_s;

  always_comb begin
    if (p_s > mid_s) k = p_s + start_s - g_s;
    else k = p_s + start_s;
  end

  // Zero the wavenumber at the Nyquist point so the products vanish.
  assign k_o  = (p_s == mid_s) ? '0 : k;
  assign nk_o = (p_s == mid_s) ? '0 : -k;

endmodule

FILE: src/sdm_mult.sv
// Output stage: two wavenumber products into the result register.
module sdm_mult
  import sdm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [SAMPLE_BITS-1:0] re_i,
  input  logic signed [SAMPLE_BITS-1:0] im_i,
  input  logic signed [K_W-1:0]         k_i,
  input  logic signed [K_W-1:0]         nk_i,
  input  logic                          last_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [OUT_W-1:0]       dre_o,
  output logic signed [OUT_W-1:0]       dim_o,
  output logic                          last_o
);

  localparam int unsigned PROD_W = SAMPLE_BITS + K_W;

  logic signed [PROD_W-1:0] prod_re, prod_im;
  logic signed [OUT_W-1:0]  dre_d, dim_d, dre_q, dim_q;
  logic                     valid_q, last_q;

  assign prod_re = nk_i * im_i;
  assign prod_im = k_i * re_i;

  // Wrap or sign-extend the full product to the output width.
  if (PROD_W >= OUT_W) begin : g_wrap
    assign dre_d = prod_re[OUT_W-1:0];
    assign dim_d = prod_im[OUT_W-1:0];
  end else begin : g_ext
    assign dre_d = {{(OUT_W-PROD_W){prod_re[PROD_W-1]}}, prod_re};
    assign dim_d = {{(OUT_W-PROD_W){prod_im[PROD_W-1]}}, prod_im};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dre_q  <= dre_d;
      dim_q  <= dim_d;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign dre_o   = dre_q;
  assign dim_o   = dim_q;
  assign last_o  = last_q;

endmodule

FILE: src/spectral_derivative_multiply.sv
// Spectral derivative: each coefficient times i*k over a walked 3-D block.
// Pipeline: input register, then result register.
// Throughput: one transaction per cycle while m_axis_tready holds; the two products share the result stage.
// Reset: position counters return to zero, registers to their defaults
// (sizes 1, axis 0, start 0, global size 1, not halved); pipeline empties.
module spectral_derivative_multiply
  import sdm_pkg::*;
#(
  parameter int unsigned MAX_LEN     = 65536,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  // coefficient stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // coef_re, coef_im (lowest bits first), zero padded
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // derivative stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // deriv_re, deriv_im (lowest bits first), zero padded
  output logic [((2*OUT_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                    m_axis_tlast   // block_end
);

  localparam int unsigned OUT_TW = ((2*OUT_W+7)/8)*8;

  cfg_t cfg;

  logic                          accept;
  logic                          mul_ready;
  logic signed [K_W-1:0]         k_c, nk_c;
  logic                          last_c;

  // Input register: coefficient plus its wavenumber.
  logic                          v1_q;
  logic signed [SAMPLE_BITS-1:0] re_q, im_q;
  logic signed [K_W-1:0]         k_q, nk_q;
  logic                          last_q;

  logic signed [OUT_W-1:0]       dre, dim;

  sdm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The input register frees up whenever the result stage can take its item.
  assign s_axis_tready = !v1_q || mul_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Counters advance once per accepted transaction; k is formed from the
  // counter values as they stand before the step.
  sdm_wavenum #(
    .MAX_LEN (MAX_LEN)
  ) u_wavenum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (accept),
    .k_o    (k_c),
    .nk_o   (nk_c),
    .last_o (last_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s_axis_tready) begin
      v1_q <= s_axis_tvalid;
    end
  end

  // Payload: hold while stalled, load on each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      re_q   <= s_axis_tdata[SAMPLE_BITS-1:0];
      im_q   <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      k_q    <= k_c;
      nk_q   <= nk_c;
      last_q <= last_c;
    end
  end

  // Result stage: deriv_re = -k*im, deriv_im = k*re.
  sdm_mult #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .ready_o (mul_ready),
    .re_i    (re_q),
    .im_i    (im_q),
    .k_i     (k_q),
    .nk_i    (nk_q),
    .last_i  (last_q),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .dre_o   (dre),
    .dim_o   (dim),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_TW-2*OUT_W){1'b0}}, dim, dre};

endmodule

FILE: dv/spectral_derivative_multiply_test.sv
// Testbench for the spectral derivative multiplier: directed table, random settings, predictor.
`timescale 1ns / 100ps

module spectral_derivative_multiply_test;
  import sdm_pkg::*;

  localparam int unsigned SAMPLE_W    = 24;
  localparam longint      MAX_LEN     = 65536;
  localparam int          PIPE_DEPTH  = 2;      // input register plus result register
  localparam int          MAX_REPORTS = 10;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RAND_PHASES = 24;
  localparam int          N_DIR       = 23;
  localparam int          IN_BYTES_W  = ((2*SAMPLE_W+7)/8)*8;
  localparam int          OUT_BYTES_W = ((2*OUT_W+7)/8)*8;

  // One expected derivative result, as it leaves the block.
  typedef struct packed {
    logic [OUT_W-1:0] re;
    logic [OUT_W-1:0] im;
    logic             last;
  } deriv_t;

  // One row of the directed table. A row whose expectation can be read off
  // directly carries it; all other rows go through the predictor.
  typedef struct packed {
    logic [2:0]          setting;
    logic [SAMPLE_W-1:0] re;
    logic [SAMPLE_W-1:0] im;
    logic                typed;
    deriv_t              want;
  } coef_row_t;

  // Pacing of the two stream sides.
  typedef enum logic [1:0] {
    PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH
  } pace_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    psel    = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite  = 1'b0;
  logic [ADDR_W-1:0]       paddr   = '0;
  logic [DATA_W-1:0]       pwdata  = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // coef_re [23:0], coef_im [47:24]
  logic [IN_BYTES_W-1:0]   s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // deriv_re [41:0], deriv_im [83:42], zero padding above
  logic [OUT_BYTES_W-1:0]  m_axis_tdata;
  logic                    m_axis_tlast;   // block_end

  // Shadow of the register file and of the position counters.
  cfg_t   regs = '{17'd1, 17'd1, 17'd1, 2'd0, 16'd0, 17'd1, 1'b0};
  longint pos_a0 = 0;
  longint pos_a1 = 0;
  longint pos_a2 = 0;

  deriv_t expected_derivs[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches       = 0;
  int results_checked  = 0;
  int coefs_sent       = 0;
  int nyquist_zeros    = 0;
  int block_ends       = 0;
  int settings_applied = 0;
  int cycle_count      = 0;

  // Register settings: 0 is the reset state, 1..3 feed the directed table,
  // 4..6 open the random part with the extremes of every register.
  cfg_t setting_table [7] = '{
    '{17'd1, 17'd1, 17'd1, 2'd0, 16'd0, 17'd1, 1'b0},
    // short walk along axis 0 with positive, Nyquist and negative wavenumbers
    '{17'd8, 17'd1, 17'd1, AXIS_0, 16'd0, 17'd8, 1'b0},
    // size zero and oversize lengths, selector three, halved axis with global size zero
    '{17'd0, 17'd131071, 17'd3, 2'd3, 16'd65535, 17'd0, 1'b1},
    // shrink the block under a counter left beyond its new length
    '{17'd2, 17'd2, 17'd2, AXIS_1, 16'd0, 17'd0, 1'b0},
    '{17'd65536, 17'd65536, 17'd65536, AXIS_0, 16'd65535, 17'd65536, 1'b1},
    '{17'd131071, 17'd131071, 17'd131071, 2'd2, 16'd0, 17'd131071, 1'b0},
    '{17'd1, 17'd1, 17'd1, AXIS_0, 16'd0, 17'd1, 1'b0}
  };

  // Directed coefficients. Under the reset setting every item sits on the
  // Nyquist point of a one-element block, so the result is zero and ends the block.
  coef_row_t dir_rows [N_DIR] = '{
    '{3'd0, 24'h000000, 24'h000000, 1'b1, '{42'd0, 42'd0, 1'b1}},
    '{3'd0, 24'h7FFFFF, 24'h800000, 1'b1, '{42'd0, 42'd0, 1'b1}},
    '{3'd0, 24'h800000, 24'h7FFFFF, 1'b1, '{42'd0, 42'd0, 1'b1}},
    '{3'd0, 24'hFFFFFF, 24'h000001, 1'b1, '{42'd0, 42'd0, 1'b1}},
    '{3'd0, 24'h555555, 24'hAAAAAA, 1'b1, '{42'd0, 42'd0, 1'b1}},
    '{3'd1, 24'h7FFFFF, 24'h800000, 1'b0, '0},
    '{3'd1, 24'h800000, 24'h7FFFFF, 1'b0, '0},
    '{3'd1, 24'h000001, 24'hFFFFFF, 1'b0, '0},
    '{3'd1, 24'h123456, 24'h654321, 1'b0, '0},
    '{3'd1, 24'h7FFFFF, 24'h7FFFFF, 1'b0, '0},
    '{3'd1, 24'h800000, 24'h800000, 1'b0, '0},
    '{3'd1, 24'hABCDEF, 24'hFEDCBA, 1'b0, '0},
    '{3'd1, 24'hFFFFFF, 24'h000001, 1'b0, '0},
    '{3'd2, 24'h800000, 24'h800000, 1'b0, '0},
    '{3'd2, 24'h7FFFFF, 24'h800000, 1'b0, '0},
    '{3'd2, 24'h800000, 24'h7FFFFF, 1'b0, '0},
    '{3'd2, 24'h0F0F0F, 24'hF0F0F0, 1'b0, '0},
    '{3'd3, 24'h7FFFFF, 24'h800000, 1'b0, '0},
    '{3'd3, 24'h000002, 24'hFFFFFD, 1'b0, '0},
    '{3'd3, 24'h800000, 24'h7FFFFF, 1'b0, '0},
    '{3'd3, 24'h3C3C3C, 24'hC3C3C3, 1'b0, '0},
    '{3'd3, 24'h000000, 24'h7FFFFF, 1'b0, '0},
    '{3'd3, 24'hFFFFFF, 24'h800000, 1'b0, '0}
  };

  spectral_derivative_multiply #(
    .MAX_LEN     (65536),
    .SAMPLE_BITS (SAMPLE_W)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_derivs.size());
      $display("spectral_derivative_multiply_test failed");
      $finish;
    end
  end

  // Block length as the hardware sees it: zero acts as one, oversize saturates.
  function automatic longint eff_len(input logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (longint'(s) > MAX_LEN) return MAX_LEN;
    return longint'(s);
  endfunction

  // Multiply one coefficient by i*k at the current walk position, then step the walk.
  function automatic deriv_t predict_derivative(input logic signed [SAMPLE_W-1:0] re_in,
                                                input logic signed [SAMPLE_W-1:0] im_in);
    longint l0, l1, l2, g, mid, p, k, re, im;
    deriv_t d;
    l0 = eff_len(regs.size_axis0);
    l1 = eff_len(regs.size_axis1);
    l2 = eff_len(regs.size_axis2);
    re = re_in;
    im = im_in;
    if (regs.deriv_axis == AXIS_0) p = pos_a0;
    else if (regs.deriv_axis == AXIS_1) p = pos_a1;
    else p = pos_a2;
    // period of the derivative axis; the halved axis folds back on 2*(n-1)
    if (regs.halved_axis) g = (longint'(regs.global_size) - 1) * 2;
    else g = longint'(regs.global_size);
    mid = g / 2 - longint'(regs.global_start);
    if (p == mid) begin
      d.re = '0;
      d.im = '0;
      nyquist_zeros++;
    end else begin
      k = p + longint'(regs.global_start);
      if (p > mid) k -= g;
      d.re = OUT_W'(-(k * im));
      d.im = OUT_W'(k * re);
    end
    d.last = (pos_a0 + 1 >= l0) && (pos_a1 + 1 >= l1) && (pos_a2 + 1 >= l2);
    if (d.last) block_ends++;
    // advance the walk, axis 0 fastest; a stale counter wraps with carry
    if (pos_a0 + 1 >= l0) begin
      pos_a0 = 0;
      if (pos_a1 + 1 >= l1) begin
        pos_a1 = 0;
        if (pos_a2 + 1 >= l2) pos_a2 = 0;
        else pos_a2 = pos_a2 + 1;
      end else begin
        pos_a1 = pos_a1 + 1;
      end
    end else begin
      pos_a0 = pos_a0 + 1;
    end
    return d;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_len();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 17'd65536;
      2:       return SIZE_W'($urandom_range(65537, 131071));
      3:       return SIZE_W'($urandom_range(1, 131071));
      default: return SIZE_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void flag_mismatch(input string field, input logic [OUT_W-1:0] want,
                                        input logic [OUT_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s at result %0d: expected %h, got %h",
               field, results_checked, want, got);
  endfunction

  task automatic set_pace(input pace_e pace);
    case (pace)
      PACE_FULL:        begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SEND_GAPS:   begin send_idle_pct = 46; recv_stall_pct = 0;  end
      PACE_RECV_STALLS: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      default:          begin send_idle_pct = 8;  recv_stall_pct = 8;  end
    endcase
  endtask

  // Offer one coefficient, hold it until the block takes it, then record the expectation.
  task automatic send_coef(input logic [SAMPLE_W-1:0] re, input logic [SAMPLE_W-1:0] im,
                           input logic typed, input deriv_t typed_want);
    deriv_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {im, re};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // the predictor always runs so its walk stays in step with the block
    predicted = predict_derivative(re, im);
    expected_derivs.push_back(typed ? typed_want : predicted);
    coefs_sent++;
  endtask

  // Drop valid and hold until every expected result is out and the pipeline is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_derivs.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the access edge.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_SIZE_AXIS0:   regs.size_axis0   = val[SIZE_W-1:0];
      REG_SIZE_AXIS1:   regs.size_axis1   = val[SIZE_W-1:0];
      REG_SIZE_AXIS2:   regs.size_axis2   = val[SIZE_W-1:0];
      REG_DERIV_AXIS:   regs.deriv_axis   = val[AXIS_W-1:0];
      REG_GLOBAL_START: regs.global_start = val[START_W-1:0];
      REG_GLOBAL_SIZE:  regs.global_size  = val[SIZE_W-1:0];
      REG_HALVED_AXIS:  regs.halved_axis  = val[0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reprogram every register once the block has gone quiet. Counters are not
  // touched by a write, so the walk continues from wherever it stood.
  task automatic apply_setting(input cfg_t s);
    drain();
    write_reg(REG_SIZE_AXIS0,   DATA_W'(s.size_axis0));
    write_reg(REG_SIZE_AXIS1,   DATA_W'(s.size_axis1));
    write_reg(REG_SIZE_AXIS2,   DATA_W'(s.size_axis2));
    write_reg(REG_DERIV_AXIS,   DATA_W'(s.deriv_axis));
    write_reg(REG_GLOBAL_START, DATA_W'(s.global_start));
    write_reg(REG_GLOBAL_SIZE,  DATA_W'(s.global_size));
    write_reg(REG_HALVED_AXIS,  DATA_W'(s.halved_axis));
    settings_applied++;
  endtask

  // Result side: check each transaction against the oldest expectation,
  // then pick the ready level for the next cycle.
  always @(posedge clk_i) begin : check_results
    deriv_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_derivs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with nothing expected: deriv_re %h deriv_im %h block_end %b",
                   m_axis_tdata[OUT_W-1:0], m_axis_tdata[2*OUT_W-1:OUT_W], m_axis_tlast);
      end else begin
        want = expected_derivs.pop_front();
        if (m_axis_tdata[OUT_W-1:0] !== want.re)
          flag_mismatch("deriv_re", want.re, m_axis_tdata[OUT_W-1:0]);
        if (m_axis_tdata[2*OUT_W-1:OUT_W] !== want.im)
          flag_mismatch("deriv_im", want.im, m_axis_tdata[2*OUT_W-1:OUT_W]);
        if (m_axis_tlast !== want.last)
          flag_mismatch("block_end", OUT_W'(want.last), OUT_W'(m_axis_tlast));
        results_checked++;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    int     n;
    cfg_t   s;
    longint g, len, target, st;
    logic [2:0] cur_setting;

    cur_setting = 3'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at full rate; a new setting is programmed when the row asks for it.
    set_pace(PACE_FULL);
    for (int r = 0; r < N_DIR; r++) begin
      if (dir_rows[r].setting != cur_setting) begin
        cur_setting = dir_rows[r].setting;
        apply_setting(setting_table[cur_setting]);
      end
      send_coef(dir_rows[r].re, dir_rows[r].im, dir_rows[r].typed, dir_rows[r].want);
    end

    // Random phases: each gets its own setting and pacing. Most settings use
    // short blocks and a start chosen so that the Nyquist point lies inside
    // the walk; the first three phases pin the register extremes.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 3) begin
        s = setting_table[4 + ph];
      end else begin
        s.size_axis0  = pick_len();
        s.size_axis1  = pick_len();
        s.size_axis2  = pick_len();
        s.deriv_axis  = AXIS_W'($urandom_range(0, 3));
        s.halved_axis = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0:       s.global_size = '0;
          1:       s.global_size = 17'd65536;
          2:       s.global_size = 17'd1;
          3:       s.global_size = SIZE_W'($urandom);
          default: s.global_size = SIZE_W'($urandom_range(2, 64));
        endcase
        if (s.halved_axis) g = (longint'(s.global_size) - 1) * 2;
        else g = longint'(s.global_size);
        if (s.deriv_axis == AXIS_0) len = eff_len(s.size_axis0);
        else if (s.deriv_axis == AXIS_1) len = eff_len(s.size_axis1);
        else len = eff_len(s.size_axis2);
        target = longint'($urandom_range(0, int'((len < 16) ? len : 16) - 1));
        st = g / 2 - target;
        case ($urandom_range(0, 7))
          0:       s.global_start = '0;
          1:       s.global_start = 16'hFFFF;
          2:       s.global_start = START_W'($urandom);
          default: s.global_start = (st >= 0 && st <= 65535) ? START_W'(st)
                                                              : START_W'($urandom);
        endcase
      end
      apply_setting(s);
      set_pace(pace_e'(ph % 4));
      n = $urandom_range(50, 100);
      for (int i = 0; i < n; i++) begin
        // hold the sender until the block has emptied completely
        if (ph % 6 == 3 && i == n / 2) drain();
        send_coef(pick_sample(), pick_sample(), 1'b0, '0);
      end
    end

    drain();
    repeat (PIPE_DEPTH * 4) @(posedge clk_i);

    $display("covered %0d coefficients under %0d register settings, %0d results checked",
             coefs_sent, settings_applied, results_checked);
    $display("walk hit %0d Nyquist zeros and %0d block ends, %0d mismatches",
             nyquist_zeros, block_ends, mismatches);
    if (mismatches == 0) begin
      $display("spectral_derivative_multiply_test passed");
    end else begin
      $display("spectral_derivative_multiply_test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/sdm_pkg.sv
src/sdm_cfg_regs.sv
src/sdm_wavenum.sv
src/sdm_mult.sv
src/spectral_derivative_multiply.sv
dv/spectral_derivative_multiply_test.sv
